// ----- rtl/cbp_pkg.sv -----
package cbp_pkg;

  localparam int GUARD_BITS = 8;
  localparam int ZW = 34;
  localparam int ATAN_W = 31;
  localparam int PHASE_W = 17;
  localparam int GAIN_HALF = 15;

  localparam logic signed [ZW-1:0] Z_QUARTER = 34'sd1073741824;
  localparam logic signed [PHASE_W-1:0] PHASE_PI = 17'sd32768;
  localparam logic signed [PHASE_W-1:0] PHASE_ZERO = 17'sd0;

  typedef struct packed {
    logic last;
    logic im_zero;
    logic re_neg;
    logic all_zero;
  } flags_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [ATAN_W-1:0] atan_of(input int idx);
    logic [ATAN_W-1:0] a;
    case (idx)
      0:  a = 31'd536870912;
      1:  a = 31'd316933406;
      2:  a = 31'd167458907;
      3:  a = 31'd85004756;
      4:  a = 31'd42667331;
      5:  a = 31'd21354465;
      6:  a = 31'd10679838;
      7:  a = 31'd5340245;
      8:  a = 31'd2670163;
      9:  a = 31'd1335087;
      10: a = 31'd667544;
      11: a = 31'd333772;
      12: a = 31'd166886;
      13: a = 31'd83443;
      14: a = 31'd41722;
      15: a = 31'd20861;
      16: a = 31'd10430;
      17: a = 31'd5215;
      18: a = 31'd2608;
      19: a = 31'd1304;
      20: a = 31'd652;
      21: a = 31'd326;
      22: a = 31'd163;
      23: a = 31'd81;
      24: a = 31'd41;
      25: a = 31'd20;
      26: a = 31'd10;
      27: a = 31'd5;
      28: a = 31'd3;
      29: a = 31'd1;
      30: a = 31'd1;
      default: a = 31'd0;
    endcase
    return a;
  endfunction

  // 1/K in Q30 for the given stage count, elaboration only
  function automatic logic [63:0] inv_gain_q30(input int stages);
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bit_v;
    logic [63:0] s;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    int k;
    p = 64'd1 << 60;
    for (k = 0; k < stages; k++) begin
      p = p + (p >> (2 * k));
    end
    n = p;
    r = 64'd0;
    bit_v = 64'd1 << 62;
    for (k = 0; k < 32; k++) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    s = (r == 64'd0) ? 64'd1 : r;
    num = (64'd1 << 60) + (s >> 1);
    q = 64'd0;
    rem = 64'd0;
    for (k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= s) begin
        rem = rem - s;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// ----- rtl/cbp_prerot.sv -----
module cbp_prerot #(
  parameter int DATA_WIDTH = 24,
  parameter int XW = 34
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [DATA_WIDTH-1:0]        in_re,
  input  logic [DATA_WIDTH-1:0]        in_im,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [XW-1:0]         out_x,
  output logic signed [XW-1:0]         out_y,
  output logic signed [cbp_pkg::ZW-1:0] out_z,
  output cbp_pkg::flags_t              out_flags
);
  import cbp_pkg::*;

  logic                  valid_r;
  logic signed [XW-1:0]  x_r, x_nxt;
  logic signed [XW-1:0]  y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  flags_t                flags_r, flags_nxt;
  logic signed [DATA_WIDTH:0] re_e, im_e, x0, y0;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    re_e = {in_re[DATA_WIDTH-1], in_re};
    im_e = {in_im[DATA_WIDTH-1], in_im};
    if (!re_e[DATA_WIDTH]) begin
      x0    = re_e;
      y0    = im_e;
      z_nxt = '0;
    end else if (!im_e[DATA_WIDTH]) begin
      x0    = im_e;
      y0    = -re_e;
      z_nxt = Z_QUARTER;
    end else begin
      x0    = -im_e;
      y0    = re_e;
      z_nxt = -Z_QUARTER;
    end
    x_nxt = {{(XW-DATA_WIDTH-1-GUARD_BITS){x0[DATA_WIDTH]}}, x0, {GUARD_BITS{1'b0}}};
    y_nxt = {{(XW-DATA_WIDTH-1-GUARD_BITS){y0[DATA_WIDTH]}}, y0, {GUARD_BITS{1'b0}}};
    flags_nxt.last     = in_last;
    flags_nxt.im_zero  = (in_im == '0);
    flags_nxt.re_neg   = in_re[DATA_WIDTH-1];
    flags_nxt.all_zero = (in_im == '0) && (in_re == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_flags = flags_r;

endmodule

// ----- rtl/cbp_cordic_stage.sv -----
module cbp_cordic_stage #(
  parameter int XW = 34,
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [XW-1:0]          in_x,
  input  logic signed [XW-1:0]          in_y,
  input  logic signed [cbp_pkg::ZW-1:0] in_z,
  input  cbp_pkg::flags_t               in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [XW-1:0]          out_x,
  output logic signed [XW-1:0]          out_y,
  output logic signed [cbp_pkg::ZW-1:0] out_z,
  output cbp_pkg::flags_t               out_flags
);
  import cbp_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = signed'({{(ZW-ATAN_W){1'b0}}, atan_of(IDX)});

  logic                  valid_r;
  logic signed [XW-1:0]  x_r, x_nxt;
  logic signed [XW-1:0]  y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  flags_t                flags_r;
  logic signed [XW-1:0]  dx, dy;

  assign in_ready = !valid_r || out_ready;

  // rotate toward the x axis, direction from the sign of y
  always_comb begin
    dx = in_y >>> IDX;
    dy = in_x >>> IDX;
    if (!in_y[XW-1]) begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ANGLE;
    end else begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      flags_r <= in_flags;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_flags = flags_r;

endmodule

// ----- rtl/cbp_post.sv -----
module cbp_post #(
  parameter int DATA_WIDTH = 24,
  parameter int XW = 34,
  parameter int CORDIC_STAGES = 18
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [XW-1:0]               in_x,
  input  logic signed [cbp_pkg::ZW-1:0]      in_z,
  input  cbp_pkg::flags_t                    in_flags,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [DATA_WIDTH-1:0]              out_magnitude,
  output logic signed [cbp_pkg::PHASE_W-1:0] out_phase_angle,
  output logic                               out_last
);
  import cbp_pkg::*;

  localparam logic [63:0] INV_GAIN = inv_gain_q30(CORDIC_STAGES);
  localparam logic [GAIN_HALF-1:0] GAIN_HI = INV_GAIN[2*GAIN_HALF-1:GAIN_HALF];
  localparam logic [GAIN_HALF-1:0] GAIN_LO = INV_GAIN[GAIN_HALF-1:0];
  localparam int UW = XW - 1;
  localparam int PW = UW + GAIN_HALF;
  localparam int SW = PW + 1;
  localparam int M1W = SW - GAIN_HALF;
  localparam int M2W = M1W + 1;
  localparam int MW = M2W - GUARD_BITS;
  localparam int PSW = ZW - 16;

  // product stage
  logic                      va_r;
  logic [PW-1:0]             hi_r, lo_r;
  logic [PW-1:0]             hi_nxt, lo_nxt;
  logic signed [PHASE_W-1:0] pha_r, pha_nxt;
  flags_t                    fa_r;
  logic [UW-1:0]             ux;
  logic signed [ZW-1:0]      z_rnd;
  logic signed [PSW-1:0]     ph_s;
  logic                      ready_a, ready_b;

  // output stage
  logic                      vb_r;
  logic [DATA_WIDTH-1:0]     mag_r, mag_nxt;
  logic signed [PHASE_W-1:0] phb_r;
  logic                      last_r;
  logic [SW-1:0]             sum;
  logic [M1W-1:0]            m1;
  logic [M2W-1:0]            m2;
  logic [MW-1:0]             m_full;

  assign ready_b  = !vb_r || out_ready;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  always_comb begin
    ux     = in_x[XW-1] ? '0 : in_x[UW-1:0];
    hi_nxt = PW'(ux) * PW'(GAIN_HI);
    lo_nxt = PW'(ux) * PW'(GAIN_LO);
    z_rnd  = in_z + (ZW'(1) <<< 15);
    ph_s   = z_rnd[ZW-1:16];
    if (ph_s > PSW'(signed'(PHASE_PI))) begin
      pha_nxt = PHASE_PI;
    end else if (ph_s < -PSW'(signed'(PHASE_PI))) begin
      pha_nxt = -PHASE_PI;
    end else begin
      pha_nxt = ph_s[PHASE_W-1:0];
    end
    // real axis: exact angle
    if (in_flags.im_zero) begin
      pha_nxt = in_flags.re_neg ? PHASE_PI : PHASE_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (ready_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready_a) begin
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
      pha_r <= pha_nxt;
      fa_r  <= in_flags;
    end
  end

  always_comb begin
    sum    = {1'b0, hi_r} + SW'(lo_r >> GAIN_HALF);
    m1     = sum[SW-1:GAIN_HALF];
    m2     = {1'b0, m1} + M2W'(1 << (GUARD_BITS - 1));
    m_full = m2[M2W-1:GUARD_BITS];
    if (|m_full[MW-1:DATA_WIDTH]) begin
      mag_nxt = '1;
    end else begin
      mag_nxt = m_full[DATA_WIDTH-1:0];
    end
    if (fa_r.all_zero) begin
      mag_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (ready_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (va_r && ready_b) begin
      mag_r  <= mag_nxt;
      phb_r  <= pha_r;
      last_r <= fa_r.last;
    end
  end

  assign out_valid       = vb_r;
  assign out_magnitude   = mag_r;
  assign out_phase_angle = phb_r;
  assign out_last        = last_r;

endmodule

// ----- rtl/complex_bin_to_polar.sv -----
// An accepted input reaches the output through every register stage below, in order.
// Throughput: one item per cycle while out_ready is high; a pre-rotation stage, then one
// register stage per micro-rotation, a gain-multiply stage and the output register.
// Each stage holds its item while the next one is full, bubbles close up.
// Reset (rst_n low at a clock edge) clears every valid bit; data registers keep content.
module complex_bin_to_polar #(
  parameter int DATA_WIDTH = 24,
  parameter int CORDIC_STAGES = 18
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [DATA_WIDTH-1:0]              in_re_part,
  input  logic [DATA_WIDTH-1:0]              in_im_part,
  input  logic                               in_last_bin,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [DATA_WIDTH-1:0]              out_magnitude,
  output logic signed [cbp_pkg::PHASE_W-1:0] out_phase_angle,
  output logic                               out_last_out
);
  import cbp_pkg::*;

  localparam int XW = DATA_WIDTH + 10;

  logic                 sv    [0:CORDIC_STAGES];
  logic                 sr    [0:CORDIC_STAGES];
  logic signed [XW-1:0] sx    [0:CORDIC_STAGES];
  logic signed [XW-1:0] sy    [0:CORDIC_STAGES];
  logic signed [ZW-1:0] sz    [0:CORDIC_STAGES];
  flags_t               sf    [0:CORDIC_STAGES];

  cbp_prerot #(
    .DATA_WIDTH(DATA_WIDTH),
    .XW(XW)
  ) u_prerot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_re    (in_re_part),
    .in_im    (in_im_part),
    .in_last  (in_last_bin),
    .out_valid(sv[0]),
    .out_ready(sr[0]),
    .out_x    (sx[0]),
    .out_y    (sy[0]),
    .out_z    (sz[0]),
    .out_flags(sf[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    cbp_cordic_stage #(
      .XW (XW),
      .IDX(i)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (sv[i]),
      .in_ready (sr[i]),
      .in_x     (sx[i]),
      .in_y     (sy[i]),
      .in_z     (sz[i]),
      .in_flags (sf[i]),
      .out_valid(sv[i+1]),
      .out_ready(sr[i+1]),
      .out_x    (sx[i+1]),
      .out_y    (sy[i+1]),
      .out_z    (sz[i+1]),
      .out_flags(sf[i+1])
    );
  end

  cbp_post #(
    .DATA_WIDTH   (DATA_WIDTH),
    .XW           (XW),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sv[CORDIC_STAGES]),
    .in_ready       (sr[CORDIC_STAGES]),
    .in_x           (sx[CORDIC_STAGES]),
    .in_z           (sz[CORDIC_STAGES]),
    .in_flags       (sf[CORDIC_STAGES]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_magnitude  (out_magnitude),
    .out_phase_angle(out_phase_angle),
    .out_last       (out_last_out)
  );

  // y of the last stage is not needed after the final rotation
  logic unused_y;
  assign unused_y = ^sy[CORDIC_STAGES];

endmodule
